@@ rtl/triangle_span_rasterizer_core_macros.svh @@
// Assertion macros for the triangle span rasterizer.
// Taken in by the RTL files that carry concurrent assertions.
`ifndef TRIANGLE_SPAN_RASTERIZER_CORE_MACROS_SVH
`define TRIANGLE_SPAN_RASTERIZER_CORE_MACROS_SVH

// Same-cycle implication.
`define TSR_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tsr assertion failed");

// Next-cycle implication.
`define TSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tsr assertion failed");

`endif

@@ rtl/tsr_pkg.sv @@
// Shared types and constants of the triangle span rasterizer.
// No dependencies.
package tsr_pkg;

	localparam int DIM_W   = 11;
	localparam int PITCH_W = 13;
	localparam int ROW_W   = 10;
	localparam int ADDR_W  = 22;
	localparam int COLOR_W = 32;
	localparam int VTX_COUNT = 3;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_DRAW = 2'd1,
		CMD_NEXT = 2'd2
	} cmd_t;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_PITCH  = 2'd2;

	localparam logic [DIM_W-1:0]   WIDTH_RST  = 11'd800;
	localparam logic [DIM_W-1:0]   HEIGHT_RST = 11'd600;
	localparam logic [PITCH_W-1:0] PITCH_RST  = 13'd800;

endpackage

@@ rtl/tsr_cmd_if.sv @@
// Command request channel of the triangle span rasterizer.
// Depends on tsr_pkg for field widths.
interface tsr_cmd_if #(parameter int COORD_BITS = 13);
	logic                             valid;
	logic                             ready;
	logic [1:0]                       command;
	logic [1:0]                       vertex_index;
	logic signed [COORD_BITS-1:0]     coord_x;
	logic signed [COORD_BITS-1:0]     coord_y;
	logic [tsr_pkg::COLOR_W-1:0]      fill_color;

	modport source(output valid, command, vertex_index, coord_x, coord_y, fill_color,
		input ready);
	modport sink(input valid, command, vertex_index, coord_x, coord_y, fill_color,
		output ready);
endinterface

@@ rtl/tsr_span_if.sv @@
// Span result channel of the triangle span rasterizer.
// Depends on tsr_pkg for field widths.
interface tsr_span_if;
	logic                        valid;
	logic                        ready;
	logic                        span_valid;
	logic [tsr_pkg::ROW_W-1:0]   span_row;
	logic [tsr_pkg::ROW_W-1:0]   span_begin;
	logic [tsr_pkg::ROW_W-1:0]   span_end;
	logic [tsr_pkg::ADDR_W-1:0]  word_address;
	logic [tsr_pkg::COLOR_W-1:0] span_color;
	logic                        last_span;

	modport source(output valid, span_valid, span_row, span_begin, span_end, word_address,
		span_color, last_span, input ready);
	modport sink(input valid, span_valid, span_row, span_begin, span_end, word_address,
		span_color, last_span, output ready);
endinterface

@@ rtl/tsr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsr_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/triangle_span_rasterizer_core.sv @@
// Top level of the triangle span rasterizer: sequencer, Bresenham edge walker,
// span scanner and APB register file. Uses tsr_pkg, tsr_cmd_if, tsr_span_if, tsr_ram.
//
// Usage: load three vertices on the cmd channel (command load, one request each),
// then send a draw request with the fill color. Each following next request
// returns one span result on the span channel: row, begin (inclusive), end
// (exclusive), word address and color, with last_span set on the final one; once
// the triangle is used up a next request returns span_valid low, last_span high.
// A load is taken in the idle state. A draw sorts the vertices and, unless all three
// share one row, for each edge prepares and sets up the edge and, if it is not flat,
// walks it with one Bresenham step per cycle on a shared stepper, then clips the row
// range. A next request reads and span-tests each table row (RAM read then span test)
// from the cursor through the row of the following span, or until the row range runs
// out, then loads the result into the output register.
// cmd.ready is high only while the sequencer is idle. The result sits in an output
// register; a stalled receiver holds it and the block still accepts the next request,
// waiting only when a new result is ready before the old one is taken.
// Reset clears vertices, row range and color and restores the register defaults;
// the edge tables need no clearing since each row is read only after the current
// triangle wrote it.
`include "triangle_span_rasterizer_core_macros.svh"

module triangle_span_rasterizer_core #(
	parameter int MAX_ROWS   = 1024,
	parameter int COORD_BITS = 13
) (
	input  logic              clk,
	input  logic              arst_n,
	tsr_cmd_if.sink           cmd,
	tsr_span_if.source        span,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = COORD_BITS + 2;
	localparam int LW = CW + 14;

	typedef logic signed [COORD_BITS-1:0] vtx_t;
	typedef logic signed [CW-1:0]         crd_t;
	typedef logic signed [LW-1:0]         cmp_t;
	typedef logic [RW-1:0]                row_t;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_PREP  = 8'b0000_0010,
		S_SETUP = 8'b0000_0100,
		S_STEP  = 8'b0000_1000,
		S_CLIP  = 8'b0001_0000,
		S_RADDR = 8'b0010_0000,
		S_REVAL = 8'b0100_0000,
		S_ROUT  = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [tsr_pkg::DIM_W-1:0]   width_q;
	logic [tsr_pkg::DIM_W-1:0]   height_q;
	logic [tsr_pkg::PITCH_W-1:0] pitch_q;
	logic                        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tsr_pkg::WIDTH_RST;
			height_q <= tsr_pkg::HEIGHT_RST;
			pitch_q  <= tsr_pkg::PITCH_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				tsr_pkg::REG_WIDTH:  width_q  <= pwdata[tsr_pkg::DIM_W-1:0];
				tsr_pkg::REG_HEIGHT: height_q <= pwdata[tsr_pkg::DIM_W-1:0];
				tsr_pkg::REG_PITCH:  pitch_q  <= pwdata[tsr_pkg::PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			tsr_pkg::REG_WIDTH:  prdata = 32'(width_q);
			tsr_pkg::REG_HEIGHT: prdata = 32'(height_q);
			tsr_pkg::REG_PITCH:  prdata = 32'(pitch_q);
			default:             prdata = 32'd0;
		endcase
	end

	// Vertex, sorted vertex and triangle state
	vtx_t vx_q [tsr_pkg::VTX_COUNT];
	vtx_t vy_q [tsr_pkg::VTX_COUNT];
	vtx_t sx_q [tsr_pkg::VTX_COUNT];
	vtx_t sy_q [tsr_pkg::VTX_COUNT];
	logic [tsr_pkg::COLOR_W-1:0] color_q;
	row_t cursor_q;
	row_t limit_q;

	// Edge walker state
	logic [1:0] edge_q;
	crd_t ax_q, ay_q, bx_q, by_q;
	crd_t dxa_q, dya_q;
	logic flat_q;
	logic steep_q;
	logic up_q;
	crd_t uc_q, wc_q, uend_q, err_q, dx_q, dy_q;

	// Scanner state
	row_t scan_row_q;
	row_t span_r_q;
	logic found_q;
	logic more_q;
	logic [tsr_pkg::ROW_W-1:0]  span_b_q;
	logic [tsr_pkg::ROW_W-1:0]  span_e_q;
	logic [tsr_pkg::ADDR_W-1:0] prod_q;

	// Output register
	logic out_valid_q;
	logic span_load;

	logic cmd_acc;
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;

	function automatic vtx_t sel3(input logic [1:0] i, input vtx_t a, input vtx_t b,
		input vtx_t c);
		case (i)
			2'd0:    return a;
			2'd1:    return b;
			default: return c;
		endcase
	endfunction

	// Vertex sort by y, first index wins ties
	vtx_t ymin1, ymax1;
	logic [1:0] mi1, ma1, mii, mai, mid;
	always_comb begin
		mi1   = (vy_q[1] < vy_q[0]) ? 2'd1 : 2'd0;
		ymin1 = (vy_q[1] < vy_q[0]) ? vy_q[1] : vy_q[0];
		mii   = (vy_q[2] < ymin1) ? 2'd2 : mi1;
		ma1   = (vy_q[1] > vy_q[0]) ? 2'd1 : 2'd0;
		ymax1 = (vy_q[1] > vy_q[0]) ? vy_q[1] : vy_q[0];
		mai   = (vy_q[2] > ymax1) ? 2'd2 : ma1;
		mid   = 2'd3 - mii - mai;
	end

	// Edge endpoints for the edge in work
	crd_t pax, pay, pbx, pby, pdx, pdy;
	always_comb begin
		case (edge_q)
			2'd0: begin
				pax = crd_t'(sx_q[0]); pay = crd_t'(sy_q[0]);
				pbx = crd_t'(sx_q[1]); pby = crd_t'(sy_q[1]);
			end
			2'd1: begin
				pax = crd_t'(sx_q[1]); pay = crd_t'(sy_q[1]);
				pbx = crd_t'(sx_q[2]); pby = crd_t'(sy_q[2]);
			end
			default: begin
				pax = crd_t'(sx_q[2]); pay = crd_t'(sy_q[2]);
				pbx = crd_t'(sx_q[0]); pby = crd_t'(sy_q[0]);
			end
		endcase
		pdx = pbx - pax;
		pdy = pby - pay;
	end

	// Setup: orient along the major axis, left to right
	logic steep;
	crd_t u1, w1, u2, w2, su1, sw1, su2, sw2, mid_sum, mid_x;
	always_comb begin
		steep   = dya_q > dxa_q;
		u1      = steep ? ay_q : ax_q;
		w1      = steep ? ax_q : ay_q;
		u2      = steep ? by_q : bx_q;
		w2      = steep ? bx_q : by_q;
		su1     = (u1 > u2) ? u2 : u1;
		sw1     = (u1 > u2) ? w2 : w1;
		su2     = (u1 > u2) ? u1 : u2;
		sw2     = (u1 > u2) ? w1 : w2;
		// round toward zero
		mid_sum = ax_q + bx_q;
		mid_x   = (mid_sum + crd_t'(mid_sum < 0)) >>> 1;
	end

	// Bresenham step
	crd_t err_n;
	assign err_n = err_q - dy_q;

	// Edge table writes
	cmp_t rows_c;
	crd_t wr_row, wr_val;
	logic wr_req, wr_en;
	always_comb begin
		rows_c = (cmp_t'(height_q) < cmp_t'(MAX_ROWS)) ? cmp_t'(height_q) : cmp_t'(MAX_ROWS);
		wr_req = 1'b0;
		wr_row = ay_q;
		wr_val = mid_x;
		if (state_q == S_SETUP) begin
			wr_req = flat_q;
		end else if (state_q == S_STEP) begin
			wr_req = 1'b1;
			wr_row = steep_q ? uc_q : wc_q;
			wr_val = steep_q ? wc_q : uc_q;
		end
		wr_en = wr_req && (wr_row >= 0) && (cmp_t'(wr_row) < rows_c);
	end

	logic [COORD_BITS-1:0] rdata [tsr_pkg::VTX_COUNT];

	for (genvar g = 0; g < tsr_pkg::VTX_COUNT; g++) begin : g_tab
		tsr_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_ROWS)) u_tab (
			.clk   (clk),
			.we    (wr_en && (edge_q == 2'(g))),
			.waddr (wr_row[RW-1:0]),
			.wdata (wr_val[COORD_BITS-1:0]),
			.raddr (scan_row_q),
			.rdata (rdata[g])
		);
	end

	// Row range clip
	cmp_t miny, maxy, clip_c, clip_l0, clip_l1, clip_c1;
	logic reject;
	always_comb begin
		miny    = cmp_t'(sy_q[0]);
		maxy    = cmp_t'(sy_q[2]);
		reject  = (miny >= cmp_t'(height_q)) || (maxy < 0);
		clip_c  = (miny < 0) ? cmp_t'(0) : miny;
		clip_l0 = (maxy > rows_c - 1) ? rows_c - 1 : maxy;
		clip_l1 = (clip_l0 < 0) ? cmp_t'(0) : clip_l0;
		clip_c1 = (clip_c > clip_l1) ? clip_l1 : clip_c;
	end

	// Span test for the row just read
	cmp_t t0, t1, t2, sa, lo, hi, wd, bb, ee;
	logic hit;
	always_comb begin
		t0  = cmp_t'(vtx_t'(rdata[0]));
		t1  = cmp_t'(vtx_t'(rdata[1]));
		t2  = cmp_t'(vtx_t'(rdata[2]));
		sa  = (cmp_t'(scan_row_q) < cmp_t'(sy_q[1])) ? t0 : t1;
		lo  = (sa > t2) ? t2 : sa;
		hi  = (sa > t2) ? sa : t2;
		wd  = cmp_t'(width_q);
		bb  = (lo < 0) ? cmp_t'(0) : lo;
		ee  = (hi >= wd) ? wd - 1 : hi;
		hit = !((lo >= wd) || (hi < 0)) && (bb < ee);
	end

	logic [RW+tsr_pkg::PITCH_W-1:0] prod_full;
	assign prod_full = scan_row_q * pitch_q;

	assign span_load = (state_q == S_ROUT) && (!out_valid_q || span.ready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			for (int i = 0; i < tsr_pkg::VTX_COUNT; i++) begin
				vx_q[i] <= '0;
				vy_q[i] <= '0;
			end
			color_q    <= '0;
			cursor_q   <= '0;
			limit_q    <= '0;
			edge_q     <= '0;
			scan_row_q <= '0;
			found_q    <= 1'b0;
			more_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						case (cmd.command)
							tsr_pkg::CMD_LOAD: begin
								if (cmd.vertex_index < 2'(tsr_pkg::VTX_COUNT)) begin
									vx_q[cmd.vertex_index] <= cmd.coord_x;
									vy_q[cmd.vertex_index] <= cmd.coord_y;
								end
							end
							tsr_pkg::CMD_DRAW: begin
								color_q  <= cmd.fill_color;
								cursor_q <= '0;
								limit_q  <= '0;
								if (mii != mai) begin
									edge_q  <= 2'd0;
									state_q <= S_PREP;
								end
							end
							tsr_pkg::CMD_NEXT: begin
								scan_row_q <= cursor_q;
								found_q    <= 1'b0;
								more_q     <= 1'b0;
								state_q    <= S_RADDR;
							end
							default: ;
						endcase
					end
				end
				S_PREP: state_q <= S_SETUP;
				S_SETUP: begin
					if (flat_q) begin
						if (edge_q == 2'd2) begin
							state_q <= S_CLIP;
						end else begin
							edge_q  <= edge_q + 2'd1;
							state_q <= S_PREP;
						end
					end else begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (uc_q == uend_q) begin
						if (edge_q == 2'd2) begin
							state_q <= S_CLIP;
						end else begin
							edge_q  <= edge_q + 2'd1;
							state_q <= S_PREP;
						end
					end
				end
				S_CLIP: begin
					if (!reject) begin
						cursor_q <= row_t'(clip_c1);
						limit_q  <= row_t'(clip_l1);
					end
					state_q <= S_IDLE;
				end
				S_RADDR: begin
					if (scan_row_q < limit_q) begin
						state_q <= S_REVAL;
					end else begin
						// no further span in range
						cursor_q <= limit_q;
						state_q  <= S_ROUT;
					end
				end
				S_REVAL: begin
					if (hit && found_q) begin
						more_q   <= 1'b1;
						cursor_q <= span_r_q + row_t'(1);
						state_q  <= S_ROUT;
					end else begin
						if (hit) begin
							found_q <= 1'b1;
						end
						scan_row_q <= scan_row_q + row_t'(1);
						state_q    <= S_RADDR;
					end
				end
				S_ROUT: begin
					if (span_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (cmd_acc && (cmd.command == tsr_pkg::CMD_DRAW)) begin
			sx_q[0] <= sel3(mii, vx_q[0], vx_q[1], vx_q[2]);
			sy_q[0] <= sel3(mii, vy_q[0], vy_q[1], vy_q[2]);
			sx_q[1] <= sel3(mid, vx_q[0], vx_q[1], vx_q[2]);
			sy_q[1] <= sel3(mid, vy_q[0], vy_q[1], vy_q[2]);
			sx_q[2] <= sel3(mai, vx_q[0], vx_q[1], vx_q[2]);
			sy_q[2] <= sel3(mai, vy_q[0], vy_q[1], vy_q[2]);
		end
		if (state_q == S_PREP) begin
			ax_q   <= pax;
			ay_q   <= pay;
			bx_q   <= pbx;
			by_q   <= pby;
			dxa_q  <= (pdx < 0) ? -pdx : pdx;
			dya_q  <= (pdy < 0) ? -pdy : pdy;
			flat_q <= (pay == pby);
		end
		if (state_q == S_SETUP) begin
			steep_q <= steep;
			uc_q    <= su1;
			wc_q    <= sw1;
			uend_q  <= su2;
			up_q    <= sw1 < sw2;
			dx_q    <= steep ? dya_q : dxa_q;
			dy_q    <= steep ? dxa_q : dya_q;
			err_q   <= (steep ? dya_q : dxa_q) >>> 1;
		end
		if (state_q == S_STEP) begin
			uc_q <= uc_q + crd_t'(1);
			if (err_n < 0) begin
				wc_q  <= up_q ? wc_q + crd_t'(1) : wc_q - crd_t'(1);
				err_q <= err_n + dx_q;
			end else begin
				err_q <= err_n;
			end
		end
		if ((state_q == S_REVAL) && hit && !found_q) begin
			span_r_q <= scan_row_q;
			span_b_q <= tsr_pkg::ROW_W'(bb);
			span_e_q <= tsr_pkg::ROW_W'(ee);
			prod_q   <= tsr_pkg::ADDR_W'(prod_full);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (span_load) begin
			out_valid_q <= 1'b1;
		end else if (span.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (span_load) begin
			span.span_valid   <= found_q;
			span.span_row     <= found_q ? tsr_pkg::ROW_W'(span_r_q) : '0;
			span.span_begin   <= found_q ? span_b_q : '0;
			span.span_end     <= found_q ? span_e_q : '0;
			span.word_address <= found_q ?
				prod_q + tsr_pkg::ADDR_W'(span_b_q) : '0;
			span.span_color   <= found_q ? color_q : '0;
			span.last_span    <= !more_q;
		end
	end

	assign span.valid = out_valid_q;

	`TSR_ASSERT(a_cursor_bound, clk, arst_n, 1'b1, cursor_q <= limit_q)
	`TSR_ASSERT(a_wr_state, clk, arst_n, wr_en, (state_q == S_SETUP) || (state_q == S_STEP))
	`TSR_ASSERT_NEXT(a_next_scan, clk, arst_n, cmd_acc && (cmd.command == tsr_pkg::CMD_NEXT), state_q == S_RADDR)
	`TSR_ASSERT(a_more_found, clk, arst_n, more_q, found_q)

endmodule

@@ bench/tb_triangle_span_rasterizer_core.sv @@
// Self-checking testbench of triangle_span_rasterizer_core: directed table, then random
// triangle sequences, checked against a behavioral span predictor kept in the bench.
// Depends on tsr_pkg, tsr_cmd_if, tsr_span_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_triangle_span_rasterizer_core;

	localparam int          TBL_ROWS   = 1024;
	localparam int          IDLE_LIMIT = 200000;
	localparam logic [1:0]  CMD_UNUSED = 2'd3;
	localparam logic [3:0]  ADDR_WIDTH  = 4'd4 * tsr_pkg::REG_WIDTH;
	localparam logic [3:0]  ADDR_HEIGHT = 4'd4 * tsr_pkg::REG_HEIGHT;
	localparam logic [3:0]  ADDR_PITCH  = 4'd4 * tsr_pkg::REG_PITCH;

	typedef struct packed {
		logic                        span_valid;
		logic [tsr_pkg::ROW_W-1:0]   span_row;
		logic [tsr_pkg::ROW_W-1:0]   span_begin;
		logic [tsr_pkg::ROW_W-1:0]   span_end;
		logic [tsr_pkg::ADDR_W-1:0]  word_address;
		logic [tsr_pkg::COLOR_W-1:0] span_color;
		logic                        last_span;
	} span_t;

	typedef struct packed {
		logic [1:0]                  command;
		logic [1:0]                  vertex_index;
		logic signed [12:0]          coord_x;
		logic signed [12:0]          coord_y;
		logic [tsr_pkg::COLOR_W-1:0] fill_color;
		logic                        fixed;
		span_t                       span;
	} request_t;

	localparam span_t NO_SPAN = '{1'b0, 10'd0, 10'd0, 10'd0, 22'd0, 32'd0, 1'b1};

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;

	tsr_cmd_if #(.COORD_BITS(13)) cmd_ch();
	tsr_span_if span_ch();

	triangle_span_rasterizer_core i_dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch), .span(span_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	int unsigned scr_w, scr_h, pitch;
	int vx[3], vy[3];
	int edge_x[3*TBL_ROWS];
	int edge_lo[3], edge_hi[3];
	int cursor, limit;
	logic [31:0] held_color;

	span_t spans_due[$];
	int errors;
	int idle_cycles;
	bit no_idle;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int rows_on_table();
		return (scr_h < TBL_ROWS) ? int'(scr_h) : TBL_ROWS;
	endfunction

	function automatic void put_row(int e, int row, int x);
		if (row >= 0 && row < rows_on_table())
			edge_x[e*TBL_ROWS + row] = x;
	endfunction

	function automatic int iabs(int v);
		return v < 0 ? -v : v;
	endfunction

	function automatic void walk_edge(int e, int x1, int y1, int x2, int y2);
		int t, dx, dy, err, sy, y;
		bit steep;
		if (y1 == y2) begin
			put_row(e, y1, (x1 + x2) / 2);
			return;
		end
		steep = iabs(y2 - y1) > iabs(x2 - x1);
		if (steep) begin
			t = x1; x1 = y1; y1 = t;
			t = x2; x2 = y2; y2 = t;
		end
		if (x1 > x2) begin
			t = x1; x1 = x2; x2 = t;
			t = y1; y1 = y2; y2 = t;
		end
		dx = iabs(x2 - x1);
		dy = iabs(y2 - y1);
		err = dx / 2;
		sy = (y1 < y2) ? 1 : -1;
		y = y1;
		for (int x = x1; x <= x2; x++) begin
			if (steep) put_row(e, x, y);
			else put_row(e, y, x);
			err -= dy;
			if (err < 0) begin
				y += sy;
				err += dx;
			end
		end
	endfunction

	function automatic bit row_span(int row, output int b, output int en);
		int sa, sb, t, w;
		sa = 0; sb = 0; w = int'(scr_w); b = 0; en = 0;
		if (row < 0 || row >= TBL_ROWS) return 1'b0;
		if (edge_lo[0] <= row && edge_hi[0] > row) sa = edge_x[row];
		if (edge_lo[1] <= row && edge_hi[1] > row) sa = edge_x[TBL_ROWS + row];
		if (edge_lo[2] <= row && edge_hi[2] > row) sb = edge_x[2*TBL_ROWS + row];
		if (sa > sb) begin t = sa; sa = sb; sb = t; end
		if (sa >= w || sb < 0) return 1'b0;
		if (sa < 0) sa = 0;
		if (sb >= w) sb = w - 1;
		if (sa >= sb) return 1'b0;
		b = sa;
		en = sb;
		return 1'b1;
	endfunction

	function automatic void setup_triangle();
		int x[3], y[3], top, bot, lo_i, hi_i, mid_i, n;
		lo_i = 0; hi_i = 0;
		for (int i = 1; i < 3; i++) begin
			if (vy[i] < vy[lo_i]) lo_i = i;
			if (vy[i] > vy[hi_i]) hi_i = i;
		end
		cursor = 0;
		limit = 0;
		if (lo_i == hi_i) return;
		mid_i = 3 - lo_i - hi_i;
		x[0] = vx[lo_i]; y[0] = vy[lo_i];
		x[1] = vx[mid_i]; y[1] = vy[mid_i];
		x[2] = vx[hi_i]; y[2] = vy[hi_i];
		for (int i = 0; i < 3; i++) begin
			n = (i + 1) % 3;
			edge_lo[i] = y[i] < y[n] ? y[i] : y[n];
			edge_hi[i] = y[i] > y[n] ? y[i] : y[n];
			walk_edge(i, x[i], y[i], x[n], y[n]);
		end
		top = y[0];
		bot = y[2];
		if (top >= int'(scr_h) || bot < 0) return;
		if (top < 0) top = 0;
		if (bot >= rows_on_table()) bot = rows_on_table() - 1;
		cursor = top;
		limit = bot;
	endfunction

	// Advance the predictor by one request; returns 1 when the request yields a span result.
	function automatic bit predict_span(request_t rq, output span_t s);
		int r, b, en, nb, ne;
		bit found, more;
		longint addr;
		s = NO_SPAN;
		found = 0; more = 0;
		case (rq.command)
			tsr_pkg::CMD_LOAD: begin
				if (rq.vertex_index < 2'd3) begin
					vx[rq.vertex_index] = int'(rq.coord_x);
					vy[rq.vertex_index] = int'(rq.coord_y);
				end
				return 1'b0;
			end
			tsr_pkg::CMD_DRAW: begin
				held_color = rq.fill_color;
				setup_triangle();
				return 1'b0;
			end
			tsr_pkg::CMD_NEXT: ;
			default: return 1'b0;
		endcase
		for (r = cursor; r < limit; r++)
			if (row_span(r, b, en)) begin found = 1; break; end
		if (!found) begin
			cursor = limit;
			return 1'b1;
		end
		cursor = r + 1;
		for (int q = cursor; q < limit; q++)
			if (row_span(q, nb, ne)) begin more = 1; break; end
		if (!more) cursor = limit;
		addr = longint'(r) * pitch + b;
		s.span_valid   = 1'b1;
		s.span_row     = r[tsr_pkg::ROW_W-1:0];
		s.span_begin   = b[tsr_pkg::ROW_W-1:0];
		s.span_end     = en[tsr_pkg::ROW_W-1:0];
		s.word_address = addr[tsr_pkg::ADDR_W-1:0];
		s.span_color   = held_color;
		s.last_span    = !more;
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int p;
		if (no_idle) return 0;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Drive one request and wait for acceptance; last reports a final or empty span.
	task automatic send_request(request_t rq, output bit last);
		int gap;
		span_t s;
		bit has;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.command      <= rq.command;
		cmd_ch.vertex_index <= rq.vertex_index;
		cmd_ch.coord_x      <= rq.coord_x;
		cmd_ch.coord_y      <= rq.coord_y;
		cmd_ch.fill_color   <= rq.fill_color;
		do @(posedge clk); while (!cmd_ch.ready);
		has = predict_span(rq, s);
		last = 1'b0;
		if (has) begin
			spans_due.push_back(rq.fixed ? rq.span : s);
			last = s.last_span;
		end
	endtask

	// Drop the request and hold until every expected result is back and the block is idle.
	task automatic drain();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		wait (spans_due.size() == 0);
		repeat (8) @(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
	endtask

	task automatic apb_write(logic [3:0] addr, logic [31:0] data);
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= addr; pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic set_screen(int unsigned w, int unsigned h, int unsigned p);
		drain();
		apb_write(ADDR_WIDTH, w);
		apb_write(ADDR_HEIGHT, h);
		apb_write(ADDR_PITCH, p);
		scr_w = w & 32'h7FF;
		scr_h = h & 32'h7FF;
		pitch = p & 32'h1FFF;
	endtask

	function automatic logic signed [12:0] near(int centre, int spread);
		int v;
		v = centre + $urandom_range(0, 2*spread) - spread;
		return v[12:0];
	endfunction

	function automatic request_t mk(logic [1:0] c, logic [1:0] vi, int x, int y,
			logic [31:0] col);
		request_t rq;
		rq = '0;
		rq.command = c; rq.vertex_index = vi;
		rq.coord_x = x[12:0]; rq.coord_y = y[12:0];
		rq.fill_color = col;
		return rq;
	endfunction

	// One random triangle: loads, a draw, then a run of next requests.
	task automatic random_triangle(inout int count);
		int mode, cx, cy, spread, n_next, order[3];
		bit last;
		request_t rq;
		mode = $urandom_range(0, 99);
		cx = $urandom_range(0, scr_w + 40) - 20;
		cy = $urandom_range(0, scr_h + 40) - 20;
		spread = (mode < 85) ? $urandom_range(1, 30) : 400;
		order[0] = $urandom_range(0, 2);
		order[1] = (order[0] + $urandom_range(1, 2)) % 3;
		order[2] = 3 - order[0] - order[1];
		for (int i = 0; i < 3; i++) begin
			rq = mk(tsr_pkg::CMD_LOAD, 2'(order[i]), 0, 0, $urandom);
			if (mode >= 95) begin
				rq.coord_x = 13'($urandom);
				rq.coord_y = 13'($urandom);
			end else begin
				rq.coord_x = near(cx, spread);
				rq.coord_y = near(cy, spread);
			end
			send_request(rq, last);
			count++;
		end
		send_request(mk(tsr_pkg::CMD_DRAW, 2'($urandom), $urandom, $urandom, $urandom),
			last);
		count++;
		n_next = $urandom_range(1, 30);
		for (int i = 0; i < n_next; i++) begin
			send_request(mk(tsr_pkg::CMD_NEXT, 2'($urandom), $urandom, $urandom, $urandom),
				last);
			count++;
			if (last && $urandom_range(0, 3) != 0) break;
		end
	endtask

	task automatic random_noise(inout int count);
		bit last;
		request_t rq;
		rq = mk(2'($urandom), 2'($urandom), $urandom, $urandom, $urandom);
		send_request(rq, last);
		if (rq.command != CMD_UNUSED &&
			!(rq.command == tsr_pkg::CMD_LOAD && rq.vertex_index == 2'd3))
			count++;
	endtask

	// result checker
	always @(posedge clk) begin
		span_t got, want;
		if (span_ch.valid && span_ch.ready) begin
			got = '{span_ch.span_valid, span_ch.span_row, span_ch.span_begin,
				span_ch.span_end, span_ch.word_address, span_ch.span_color,
				span_ch.last_span};
			if (spans_due.size() == 0) begin
				$error("span result with none expected");
				errors++;
			end else begin
				want = spans_due.pop_front();
				if (got.span_valid !== want.span_valid) begin
					$error("span_valid: expected %0d, got %0d", want.span_valid, got.span_valid);
					errors++;
				end
				if (got.span_row !== want.span_row) begin
					$error("span_row: expected %0d, got %0d", want.span_row, got.span_row);
					errors++;
				end
				if (got.span_begin !== want.span_begin) begin
					$error("span_begin: expected %0d, got %0d", want.span_begin,
						got.span_begin);
					errors++;
				end
				if (got.span_end !== want.span_end) begin
					$error("span_end: expected %0d, got %0d", want.span_end, got.span_end);
					errors++;
				end
				if (got.word_address !== want.word_address) begin
					$error("word_address: expected %0h, got %0h", want.word_address,
						got.word_address);
					errors++;
				end
				if (got.span_color !== want.span_color) begin
					$error("span_color: expected %0h, got %0h", want.span_color,
						got.span_color);
					errors++;
				end
				if (got.last_span !== want.last_span) begin
					$error("last_span: expected %0d, got %0d", want.last_span, got.last_span);
					errors++;
				end
			end
		end
	end

	// hold ready low in random stretches
	initial begin
		int stall;
		stall = 0;
		span_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				span_ch.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 99) < 25) begin
				stall = pick_gap();
				span_ch.ready <= (stall == 0);
			end else begin
				span_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (span_ch.valid && span_ch.ready) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		request_t plan[];
		bit last;
		int count, chunk;
		errors = 0;
		idle_cycles = 0;
		no_idle = 0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		cmd_ch.valid = 1'b0; cmd_ch.command = tsr_pkg::CMD_LOAD; cmd_ch.vertex_index = '0;
		cmd_ch.coord_x = '0; cmd_ch.coord_y = '0; cmd_ch.fill_color = '0;
		scr_w = tsr_pkg::WIDTH_RST; scr_h = tsr_pkg::HEIGHT_RST; pitch = tsr_pkg::PITCH_RST;
		vx = '{0, 0, 0}; vy = '{0, 0, 0};
		edge_lo = '{0, 0, 0}; edge_hi = '{0, 0, 0};
		cursor = 0; limit = 0; held_color = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		plan = new[22];
		plan[0]  = mk(tsr_pkg::CMD_NEXT, 0, 0, 0, 0);
		plan[0].fixed = 1; plan[0].span = NO_SPAN;
		plan[1]  = mk(tsr_pkg::CMD_LOAD, 0, -4096, -4096, 0);
		plan[2]  = mk(tsr_pkg::CMD_LOAD, 1, 4095, 4095, 0);
		plan[3]  = mk(tsr_pkg::CMD_LOAD, 2, -4096, 4095, 0);
		plan[4]  = mk(tsr_pkg::CMD_LOAD, 3, 4095, -1, 0);
		plan[5]  = mk(CMD_UNUSED, 3, -1, -1, 32'hFFFF_FFFF);
		plan[6]  = mk(tsr_pkg::CMD_DRAW, 0, 0, 0, 32'hFFFF_FFFF);
		plan[7]  = mk(tsr_pkg::CMD_NEXT, 0, 0, 0, 0);
		plan[8]  = mk(tsr_pkg::CMD_NEXT, 0, 0, 0, 0);
		// flat top edge stores its midpoint
		plan[9]  = mk(tsr_pkg::CMD_LOAD, 0, 10, 10, 0);
		plan[10] = mk(tsr_pkg::CMD_LOAD, 1, 51, 10, 0);
		plan[11] = mk(tsr_pkg::CMD_LOAD, 2, 30, 14, 0);
		plan[12] = mk(tsr_pkg::CMD_DRAW, 0, 0, 0, 32'h0000_0000);
		plan[13] = mk(tsr_pkg::CMD_NEXT, 0, 0, 0, 0);
		plan[14] = mk(tsr_pkg::CMD_NEXT, 0, 0, 0, 0);
		plan[15] = mk(tsr_pkg::CMD_NEXT, 0, 0, 0, 0);
		// all vertices on one row
		plan[16] = mk(tsr_pkg::CMD_LOAD, 1, 70, 10, 0);
		plan[17] = mk(tsr_pkg::CMD_LOAD, 2, 90, 10, 0);
		plan[18] = mk(tsr_pkg::CMD_DRAW, 0, 0, 0, 32'h1234_5678);
		plan[19] = mk(tsr_pkg::CMD_NEXT, 0, 0, 0, 0);
		plan[19].fixed = 1; plan[19].span = NO_SPAN;
		// below the screen
		plan[20] = mk(tsr_pkg::CMD_LOAD, 0, 5, 700, 0);
		plan[21] = mk(tsr_pkg::CMD_DRAW, 0, 0, 0, 32'hA5A5_A5A5);
		foreach (plan[i]) send_request(plan[i], last);
		send_request(mk(tsr_pkg::CMD_LOAD, 1, 5, 650, 0), last);
		send_request(mk(tsr_pkg::CMD_LOAD, 2, 9, 4000, 0), last);
		send_request(mk(tsr_pkg::CMD_DRAW, 0, 0, 0, 1), last);
		send_request(mk(tsr_pkg::CMD_NEXT, 0, 0, 0, 0), last);

		count = 0;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				1: set_screen(1024, 1024, 4096);
				2: set_screen(1, 1, 1);
				3: set_screen(37, 20, 4095);
				4: set_screen($urandom_range(1, 1024), $urandom_range(1, 1024),
					$urandom_range(1, 4096));
				5: set_screen(800, 600, 800);
				default: ;
			endcase
			no_idle = (phase == 3);
			chunk = 0;
			while (chunk < 135) begin
				if ($urandom_range(0, 9) < 8) random_triangle(chunk);
				else random_noise(chunk);
				if ($urandom_range(0, 30) == 0) drain();
			end
			count += chunk;
		end

		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		wait (spans_due.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && spans_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tsr_pkg.sv
rtl/tsr_cmd_if.sv
rtl/tsr_span_if.sv
rtl/tsr_ram.sv
rtl/triangle_span_rasterizer_core.sv
bench/tb_triangle_span_rasterizer_core.sv
